// ===== hdl/pmc_pkg.sv =====
// Package for the point mean/covariance block: widths, action codes,
// the work-queue entry, divider request/response and finish-sequencer states.
// No dependencies.
package pmc_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int MAX_POINTS = 65536;
    localparam int CNT_BITS   = 17;
    localparam int SUM_BITS   = 32;
    localparam int PROD_BITS  = 48;
    localparam int SQR_BITS   = 2 * COORD_BITS;
    localparam int MEAN_BITS  = 24;
    localparam int VAR_BITS   = 39;
    localparam int COV_BITS   = 40;
    localparam int DIFF_BITS  = 64;
    localparam int DEN_BITS   = 33;
    localparam int HALF_BITS  = PROD_BITS / 2;
    localparam int DIV_BITS   = DIFF_BITS + FRAC_BITS;
    localparam int REM_BITS   = DEN_BITS + 1;
    localparam int DCNT_BITS  = $clog2(DIV_BITS + 1);
    localparam int N_TERMS    = 9;
    localparam int N_MEANS    = 3;
    localparam int TERM_BITS  = 4;
    localparam int Q_DEPTH    = 4;
    localparam int Q_ABITS    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        ACT_ADD        = 2'd0,
        ACT_ADD_FINISH = 2'd1,
        ACT_FINISH     = 2'd2,
        ACT_NONE       = 2'd3
    } t_action;

    typedef struct packed {
        logic                         add;
        logic                         finish;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic signed [SQR_BITS-1:0]   xx;
        logic signed [SQR_BITS-1:0]   xy;
        logic signed [SQR_BITS-1:0]   xz;
        logic signed [SQR_BITS-1:0]   yy;
        logic signed [SQR_BITS-1:0]   yz;
        logic signed [SQR_BITS-1:0]   zz;
    } t_work;

    typedef struct packed {
        logic                        start;
        logic signed [DIFF_BITS-1:0] num;
        logic [DEN_BITS-1:0]         den;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [COV_BITS-1:0] quo;
    } t_div_rsp;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_SQUARE,
        FS_PROD,
        FS_PROD_HI,
        FS_DIFF,
        FS_DIV_START,
        FS_DIV_WAIT,
        FS_EMIT
    } t_fin_state;

endpackage

// ===== hdl/pmc_in_if.sv =====
// Point input channel: valid/ready handshake with action and coordinates.
// Depends on pmc_pkg.
interface pmc_in_if;
    import pmc_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic signed [COORD_BITS-1:0] z_coord;
    modport source (output valid, action, x_coord, y_coord, z_coord, input ready);
    modport sink (input valid, action, x_coord, y_coord, z_coord, output ready);
endinterface

// ===== hdl/pmc_out_if.sv =====
// Result channel: valid/ready handshake with mean, covariance, count, overflow.
// Depends on pmc_pkg.
interface pmc_out_if;
    import pmc_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [MEAN_BITS-1:0] mean_x;
    logic signed [MEAN_BITS-1:0] mean_y;
    logic signed [MEAN_BITS-1:0] mean_z;
    logic [VAR_BITS-1:0]         cov_xx;
    logic signed [COV_BITS-1:0]  cov_xy;
    logic signed [COV_BITS-1:0]  cov_xz;
    logic [VAR_BITS-1:0]         cov_yy;
    logic signed [COV_BITS-1:0]  cov_yz;
    logic [VAR_BITS-1:0]         cov_zz;
    logic [CNT_BITS-1:0]         point_count;
    logic                        overflow;
    modport source (output valid, mean_x, mean_y, mean_z, cov_xx, cov_xy, cov_xz,
                    cov_yy, cov_yz, cov_zz, point_count, overflow, input ready);
    modport sink (input valid, mean_x, mean_y, mean_z, cov_xx, cov_xy, cov_xz,
                  cov_yy, cov_yz, cov_zz, point_count, overflow, output ready);
endinterface

// ===== hdl/point_mean_covariance.sv =====
// Streaming 3D point mean and covariance, top level.
// Depends on pmc_pkg, pmc_in_if, pmc_out_if, pmc_front, pmc_queue, pmc_back.
//
// i_pt carries points (action, x/y/z) with valid/ready; o_res carries one
// result per finish request. Action 0 adds a point, 1 adds and finishes,
// 2 finishes only, 3 is dropped. Points past 65536 in a set are not added
// and raise the overflow flag of that set's result.
// Points: one per cycle while the back end is idle; during a finish the
// front stage and the 4-entry queue absorb five more entries, then i_pt.ready
// drops until the finish completes.
// Finish: from the finish entry leaving the queue to o_res.valid, the back
// end forms N^2, runs each mean term and each covariance term through a
// 72-step bit-serial divider, then emits the result. An empty set emits
// at once.
// While a result waits on o_res.ready, points keep accumulating into the
// next set; a second finish holds in the queue until the result is taken.
// Synchronous reset clears the count, sums, flag, queue and result valid.
module point_mean_covariance (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pmc_in_if.sink    i_pt,
    pmc_out_if.source o_res
);
    import pmc_pkg::*;

    t_work q_in;
    t_work q_head;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;

    pmc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_work  (q_in)
    );

    pmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pmc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule

// ===== hdl/pmc_front.sv =====
// Front end: accepts points, decodes the action, forms the six coordinate
// products and holds them in one stage register. Depends on pmc_pkg, pmc_in_if.
module pmc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pmc_in_if.sink        i_pt,
    input  logic          i_full,
    output logic          o_push,
    output pmc_pkg::t_work o_work
);
    import pmc_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;
    logic  accept;

    assign i_pt.ready = !r_valid || !i_full;
    assign accept     = i_pt.valid && i_pt.ready;
    assign o_push     = r_valid && !i_full;
    assign o_work     = r_work;

    always_comb begin
        n_work        = r_work;
        n_work.add    = (i_pt.action == ACT_ADD) || (i_pt.action == ACT_ADD_FINISH);
        n_work.finish = (i_pt.action == ACT_ADD_FINISH) || (i_pt.action == ACT_FINISH);
        n_work.x      = i_pt.x_coord;
        n_work.y      = i_pt.y_coord;
        n_work.z      = i_pt.z_coord;
        n_work.xx     = i_pt.x_coord * i_pt.x_coord;
        n_work.xy     = i_pt.x_coord * i_pt.y_coord;
        n_work.xz     = i_pt.x_coord * i_pt.z_coord;
        n_work.yy     = i_pt.y_coord * i_pt.y_coord;
        n_work.yz     = i_pt.y_coord * i_pt.z_coord;
        n_work.zz     = i_pt.z_coord * i_pt.z_coord;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            // drop the unused action here
            r_valid <= (i_pt.action != ACT_NONE);
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_work <= n_work;
        end
    end

endmodule

// ===== hdl/pmc_queue.sv =====
// Short FIFO of decoded work entries between front and back end.
// Depends on pmc_pkg.
module pmc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pmc_pkg::t_work i_data,
    input  logic           i_pop,
    output pmc_pkg::t_work o_data,
    output logic           o_full,
    output logic           o_empty
);
    import pmc_pkg::*;

    t_work              r_mem [Q_DEPTH];
    logic [Q_ABITS-1:0] r_wr;
    logic [Q_ABITS-1:0] r_rd;
    logic [Q_ABITS:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_ABITS + 1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hdl/pmc_div.sv =====
// Bit-serial restoring divider: floor(num * 2^FRAC_BITS / den), one quotient
// bit per cycle, signed numerator, positive denominator. Depends on pmc_pkg.
module pmc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pmc_pkg::t_div_req i_req,
    output pmc_pkg::t_div_rsp o_rsp
);
    import pmc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DCNT_BITS-1:0] r_cnt;
    logic [REM_BITS-1:0]  r_rem;
    logic [DIV_BITS-1:0]  r_dq;
    logic [DEN_BITS-1:0]  r_den;
    logic                 r_neg;

    logic [DIFF_BITS-1:0] mag;
    logic [REM_BITS-1:0]  shifted;
    logic                 fits;
    logic [DIV_BITS-1:0]  q_adj;

    assign mag     = i_req.num[DIFF_BITS-1] ? (~i_req.num + 1'b1) : i_req.num;
    assign shifted = {r_rem[REM_BITS-2:0], r_dq[DIV_BITS-1]};
    assign fits    = (shifted >= {1'b0, r_den});
    // floor for negative values: round magnitude up when a remainder is left
    assign q_adj   = r_neg ? (~(r_dq + DIV_BITS'(r_rem != '0)) + 1'b1) : r_dq;

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = q_adj[COV_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_BITS'(DIV_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dq  <= {mag, FRAC_BITS'(0)};
            r_rem <= '0;
            r_den <= i_req.den;
            r_neg <= i_req.num[DIFF_BITS-1];
        end else if (r_busy) begin
            r_rem <= fits ? (shifted - {1'b0, r_den}) : shifted;
            r_dq  <= {r_dq[DIV_BITS-2:0], fits};
        end
    end

endmodule

// ===== hdl/pmc_back.sv =====
// Back end: pops work entries, keeps the count and the running sums, and
// sequences the finish through the shared divider. Depends on pmc_pkg,
// pmc_out_if, pmc_div.
module pmc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pmc_pkg::t_work i_head,
    input  logic           i_empty,
    output logic           o_pop,
    pmc_out_if.source      o_res
);
    import pmc_pkg::*;

    t_fin_state r_state;
    t_fin_state n_state;

    logic [CNT_BITS-1:0]         r_count;
    logic                        r_dropped;
    logic signed [SUM_BITS-1:0]  r_sx, r_sy, r_sz;
    logic signed [PROD_BITS-1:0] r_sxx, r_sxy, r_sxz, r_syy, r_syz, r_szz;

    logic [TERM_BITS-1:0]        r_term;
    logic [DEN_BITS-1:0]         r_n2;
    logic signed [DIFF_BITS-1:0] r_ss;
    logic [CNT_BITS+HALF_BITS-1:0]       r_pp_lo;
    logic signed [CNT_BITS+HALF_BITS:0]  r_pp_hi;
    logic signed [DIFF_BITS-1:0] r_diff;
    logic [COV_BITS-1:0]         r_res [N_TERMS];

    logic                        r_out_valid;
    logic [CNT_BITS-1:0]         r_out_count;
    logic                        r_out_ovf;

    logic signed [SUM_BITS-1:0]  sa, sb;
    logic signed [PROD_BITS-1:0] sab;
    logic                        div_start;
    logic                        empty_set;
    t_div_req                    div_req;
    t_div_rsp                    div_rsp;

    assign empty_set = !i_head.add && (r_count == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: begin
                if (o_pop && i_head.finish) begin
                    n_state = empty_set ? FS_EMIT : FS_SQUARE;
                end
            end
            FS_SQUARE:    n_state = FS_PROD;
            FS_PROD:      n_state = (r_term < TERM_BITS'(N_MEANS)) ? FS_DIV_START : FS_PROD_HI;
            FS_PROD_HI:   n_state = FS_DIFF;
            FS_DIFF:      n_state = FS_DIV_START;
            FS_DIV_START: n_state = FS_DIV_WAIT;
            FS_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_term == TERM_BITS'(N_TERMS - 1)) ? FS_EMIT : FS_PROD;
                end
            end
            FS_EMIT:      n_state = FS_IDLE;
            default:      n_state = FS_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop     = 1'b0;
        div_start = 1'b0;
        case (r_state)
            FS_IDLE:      o_pop = !i_empty && !(i_head.finish && r_out_valid);
            FS_DIV_START: div_start = 1'b1;
            default: begin
                o_pop     = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    // operand selection for the current term
    always_comb begin
        sa  = '0;
        sb  = '0;
        sab = '0;
        case (r_term)
            4'd0: sa = r_sx;
            4'd1: sa = r_sy;
            4'd2: sa = r_sz;
            4'd3: begin sa = r_sx; sb = r_sx; sab = r_sxx; end
            4'd4: begin sa = r_sx; sb = r_sy; sab = r_sxy; end
            4'd5: begin sa = r_sx; sb = r_sz; sab = r_sxz; end
            4'd6: begin sa = r_sy; sb = r_sy; sab = r_syy; end
            4'd7: begin sa = r_sy; sb = r_sz; sab = r_syz; end
            4'd8: begin sa = r_sz; sb = r_sz; sab = r_szz; end
            default: begin sa = '0; sb = '0; sab = '0; end
        endcase
    end

    assign div_req.start = div_start;
    assign div_req.num   = r_diff;
    assign div_req.den   = (r_term < TERM_BITS'(N_MEANS)) ? DEN_BITS'(r_count) : r_n2;

    pmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FS_IDLE;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sz        <= '0;
            r_sxx       <= '0;
            r_sxy       <= '0;
            r_sxz       <= '0;
            r_syy       <= '0;
            r_syz       <= '0;
            r_szz       <= '0;
            r_out_valid <= 1'b0;
            r_term      <= '0;
        end else begin
            r_state <= n_state;
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && i_head.add) begin
                if (r_count < CNT_BITS'(MAX_POINTS)) begin
                    r_count <= r_count + 1'b1;
                    r_sx    <= r_sx + i_head.x;
                    r_sy    <= r_sy + i_head.y;
                    r_sz    <= r_sz + i_head.z;
                    r_sxx   <= r_sxx + i_head.xx;
                    r_sxy   <= r_sxy + i_head.xy;
                    r_sxz   <= r_sxz + i_head.xz;
                    r_syy   <= r_syy + i_head.yy;
                    r_syz   <= r_syz + i_head.yz;
                    r_szz   <= r_szz + i_head.zz;
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (r_state == FS_SQUARE) begin
                r_term <= '0;
            end else if (r_state == FS_DIV_WAIT && div_rsp.done) begin
                r_term <= r_term + 1'b1;
            end
            if (r_state == FS_EMIT) begin
                // hand off the result and start a new set
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_dropped   <= 1'b0;
                r_sx        <= '0;
                r_sy        <= '0;
                r_sz        <= '0;
                r_sxx       <= '0;
                r_sxy       <= '0;
                r_sxz       <= '0;
                r_syy       <= '0;
                r_syz       <= '0;
                r_szz       <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            FS_IDLE: begin
                if (o_pop && i_head.finish && empty_set) begin
                    // empty set: zero mean, identity covariance
                    for (int i = 0; i < N_TERMS; i++) begin
                        r_res[i] <= (i == 3 || i == 6 || i == 8) ?
                                    COV_BITS'(1) << FRAC_BITS : '0;
                    end
                end
            end
            FS_SQUARE: r_n2 <= DEN_BITS'(r_count * r_count);
            FS_PROD: begin
                r_diff  <= DIFF_BITS'(sa);
                r_ss    <= sa * sb;
                r_pp_lo <= r_count * sab[HALF_BITS-1:0];
            end
            FS_PROD_HI: begin
                r_pp_hi <= $signed({1'b0, r_count}) * $signed(sab[PROD_BITS-1:HALF_BITS]);
            end
            FS_DIFF: begin
                r_diff <= (DIFF_BITS'(r_pp_hi) <<< HALF_BITS)
                          + DIFF_BITS'(r_pp_lo) - r_ss;
            end
            FS_DIV_WAIT: begin
                if (div_rsp.done) begin
                    r_res[r_term] <= div_rsp.quo;
                end
            end
            FS_EMIT: begin
                r_out_count <= r_count;
                r_out_ovf   <= r_dropped;
            end
            default: begin
                r_n2 <= r_n2;
            end
        endcase
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.mean_x      = r_res[0][MEAN_BITS-1:0];
    assign o_res.mean_y      = r_res[1][MEAN_BITS-1:0];
    assign o_res.mean_z      = r_res[2][MEAN_BITS-1:0];
    assign o_res.cov_xx      = r_res[3][VAR_BITS-1:0];
    assign o_res.cov_xy      = r_res[4];
    assign o_res.cov_xz      = r_res[5];
    assign o_res.cov_yy      = r_res[6][VAR_BITS-1:0];
    assign o_res.cov_yz      = r_res[7];
    assign o_res.cov_zz      = r_res[8][VAR_BITS-1:0];
    assign o_res.point_count = r_out_count;
    assign o_res.overflow    = r_out_ovf;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_POINTS))
        else $error("point count above capacity");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_DIV_WAIT) |-> (div_rsp.busy || div_rsp.done))
        else $error("waiting on an idle divider");

    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == FS_EMIT))
        else $error("result raised outside emit");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

endmodule
